[src/mw2w_pkg.sv]
// ----------------------------------------------------------------------------
// mw2w_pkg
// Shared widths, register codes, reset values and the CORDIC angle table for
// the mecanum world-to-wheel speed block.
// ----------------------------------------------------------------------------
package mw2w_pkg;

  // CORDIC datapath width: x and y in Q30, z in Q29, with headroom
  localparam int CW        = 34;
  localparam int STAGE_CAP = 24;

  localparam logic signed [CW-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [CW-1:0] HALF_PI_Q29 = 34'sd843314857;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  // configuration register indexes
  localparam logic [1:0] CFG_LEVER_SUM = 2'd0;
  localparam logic [1:0] CFG_DEAD_BAND = 2'd1;
  localparam logic [1:0] CFG_MAX_SPEED = 2'd2;

  localparam logic [7:0]  LEVER_SUM_RST = 8'd20;
  localparam logic [15:0] DEAD_BAND_RST = 16'd0;
  // 8000 * 2000 * 10 / 60, truncated
  localparam logic [21:0] MAX_SPEED_RST = 22'd2666666;

  // atan(2^-i) in Q29; beyond the table the angle equals 2^-i
  function automatic logic signed [CW-1:0] atan_q29(int i);
    logic signed [CW-1:0] a;
    case (i)
      0:       a = 34'sd421657428;
      1:       a = 34'sd248918915;
      2:       a = 34'sd131521918;
      3:       a = 34'sd66762579;
      4:       a = 34'sd33510843;
      5:       a = 34'sd16771758;
      6:       a = 34'sd8387925;
      7:       a = 34'sd4194219;
      8:       a = 34'sd2097141;
      9:       a = 34'sd1048575;
      default: a = 34'sd1 <<< (29 - i);
    endcase
    return a;
  endfunction

endpackage

[src/mecanum_world_to_wheel_speeds.sv]
// ----------------------------------------------------------------------------
// mecanum_world_to_wheel_speeds
// Rotates a world-frame velocity command into the robot frame and forms four
// dead-banded, saturated mecanum wheel targets.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------------
//  command  in         in_valid_i / in_stall_o   world_vx, world_vy, turn_rate,
//                                                heading
//  wheels   out        out_valid_o / out_stall_i wheel_one .. wheel_four
//  config   in         cfg_we_i                  cfg_index_i, cfg_data_i
//
//  One fold stage, one stage per CORDIC iteration (capped at 24), then
//  scaling, multiply, truncate, wheel sum and limiter stages. One beat
//  enters per cycle while in_stall_o is low; the CORDIC chain is fully
//  pipelined. Reset clears every valid bit and loads the register defaults.
//  A stall holds only the stages that cannot drain: any bubble in the pipe
//  lets a new beat in while a finished result waits at the output.
//
module mecanum_world_to_wheel_speeds #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [21:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] world_vx_i,
  input  logic signed [15:0] world_vy_i,
  input  logic signed [15:0] turn_rate_i,
  input  logic signed [15:0] heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [22:0] wheel_one_o,
  output logic signed [22:0] wheel_two_o,
  output logic signed [22:0] wheel_three_o,
  output logic signed [22:0] wheel_four_o
);

  localparam int CW   = mw2w_pkg::CW;
  localparam int NS   = (CORDIC_STAGES > mw2w_pkg::STAGE_CAP) ?
                        mw2w_pkg::STAGE_CAP : CORDIC_STAGES;
  localparam int PS   = NS + 1;  // scale to Q1.15
  localparam int MS   = NS + 2;  // products
  localparam int TS   = NS + 3;  // truncate and rotate sums
  localparam int SS   = NS + 4;  // wheel sums
  localparam int LAST = NS + 5;  // limiter, output register

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  lever_sum_q;
  logic [15:0] dead_band_q;
  logic [21:0] max_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lever_sum_q <= mw2w_pkg::LEVER_SUM_RST;
      dead_band_q <= mw2w_pkg::DEAD_BAND_RST;
      max_speed_q <= mw2w_pkg::MAX_SPEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mw2w_pkg::CFG_LEVER_SUM: lever_sum_q <= cfg_data_i[7:0];
        mw2w_pkg::CFG_DEAD_BAND: dead_band_q <= cfg_data_i[15:0];
        mw2w_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits and advance control
  // A stage loads when it is empty or when every stage below it up to the
  // output can move; no dependent chain, each term is an independent AND.
  // --------------------------------------------------------------------------
  logic [LAST:0] v_q;
  logic [LAST:0] rdy;

  always_comb begin
    logic [LAST:0] low_mask;
    for (int k = 0; k <= LAST; k++) begin
      // mask off the stages above this one, keep this stage to the output
      low_mask = ~({(LAST+1){1'b1}} << k);
      rdy[k]   = !(&(v_q | low_mask)) || !out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k <= LAST; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[LAST];

  // --------------------------------------------------------------------------
  // Fold stage: heading to Q29, fold by pi into the convergence range
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] x_q [0:NS];
  logic signed [CW-1:0] y_q [0:NS];
  logic signed [CW-1:0] z_q [0:NS];
  logic                 neg_q [0:NS];
  logic signed [15:0]   vx_q [0:PS];
  logic signed [15:0]   vy_q [0:PS];
  logic signed [15:0]   w_q  [0:PS];

  logic signed [CW-1:0] z_in;
  assign z_in = {{(CW-32){heading_i[15]}}, heading_i, 16'b0};

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      x_q[0]  <= mw2w_pkg::GAIN_Q30;
      y_q[0]  <= '0;
      vx_q[0] <= world_vx_i;
      vy_q[0] <= world_vy_i;
      w_q[0]  <= turn_rate_i;
      priority if (z_in > mw2w_pkg::HALF_PI_Q29) begin
        z_q[0]   <= z_in - mw2w_pkg::PI_Q29;
        neg_q[0] <= 1'b1;
      end else if (z_in < -mw2w_pkg::HALF_PI_Q29) begin
        z_q[0]   <= z_in + mw2w_pkg::PI_Q29;
        neg_q[0] <= 1'b1;
      end else begin
        z_q[0]   <= z_in;
        neg_q[0] <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC rotation stages, one iteration per register stage
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= NS; k++) begin : g_cordic
    localparam int I = k - 1;
    logic signed [CW-1:0] dx, dy, ang;

    assign dx  = y_q[k-1] >>> I;
    assign dy  = x_q[k-1] >>> I;
    assign ang = mw2w_pkg::atan_q29(I);

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_q[k-1]) begin
        neg_q[k] <= neg_q[k-1];
        vx_q[k]  <= vx_q[k-1];
        vy_q[k]  <= vy_q[k-1];
        w_q[k]   <= w_q[k-1];
        // rotate towards zero residual; zero counts as positive
        if (!z_q[k-1][CW-1]) begin
          x_q[k] <= x_q[k-1] - dx;
          y_q[k] <= y_q[k-1] + dy;
          z_q[k] <= z_q[k-1] - ang;
        end else begin
          x_q[k] <= x_q[k-1] + dx;
          y_q[k] <= y_q[k-1] - dy;
          z_q[k] <= z_q[k-1] + ang;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scale stage: undo the fold, floor to Q1.15 and saturate
  // --------------------------------------------------------------------------
  function automatic logic signed [15:0] to_q15(logic signed [CW-1:0] v);
    logic signed [CW-1:0]  t;
    logic signed [CW-16:0] sh;
    t  = v >>> 15;
    sh = t[CW-16:0];
    if (sh > 19'sd32767)       return 16'sd32767;
    else if (sh < -19'sd32768) return -16'sd32768;
    else                       return sh[15:0];
  endfunction

  logic signed [CW-1:0] xf, yf;
  logic signed [15:0]   cos_q, sin_q;

  assign xf = neg_q[NS] ? -x_q[NS] : x_q[NS];
  assign yf = neg_q[NS] ? -y_q[NS] : y_q[NS];

  always_ff @(posedge clk_i) begin
    if (rdy[PS] && v_q[NS]) begin
      cos_q    <= to_q15(xf);
      sin_q    <= to_q15(yf);
      vx_q[PS] <= vx_q[NS];
      vy_q[PS] <= vy_q[NS];
      w_q[PS]  <= w_q[NS];
    end
  end

  // --------------------------------------------------------------------------
  // Multiply stage: four rotation products and the turn term
  // --------------------------------------------------------------------------
  logic signed [31:0] p_vxc_q, p_vys_q, p_vxs_q, p_vyc_q;
  logic signed [24:0] turn_q, turn_t_q;

  always_ff @(posedge clk_i) begin
    if (rdy[MS] && v_q[PS]) begin
      p_vxc_q <= vx_q[PS] * cos_q;
      p_vys_q <= vy_q[PS] * sin_q;
      p_vxs_q <= vx_q[PS] * sin_q;
      p_vyc_q <= vy_q[PS] * cos_q;
      turn_q  <= w_q[PS] * $signed({1'b0, lever_sum_q});
    end
  end

  // --------------------------------------------------------------------------
  // Truncate stage: drop Q15 fraction toward zero, form robot-frame speeds
  // --------------------------------------------------------------------------
  function automatic logic signed [16:0] trunc_q15(logic signed [31:0] p);
    logic signed [32:0] b;
    b = {p[31], p} + (p[31] ? 33'sd32767 : 33'sd0);
    return b[31:15];
  endfunction

  logic signed [17:0] rvy_q, rvx_q;

  always_ff @(posedge clk_i) begin
    if (rdy[TS] && v_q[MS]) begin
      rvy_q    <= 18'(trunc_q15(p_vxc_q)) + 18'(trunc_q15(p_vys_q));
      rvx_q    <= 18'(trunc_q15(p_vxs_q)) - 18'(trunc_q15(p_vyc_q));
      turn_t_q <= turn_q;
    end
  end

  // --------------------------------------------------------------------------
  // Wheel sum stage
  // --------------------------------------------------------------------------
  logic signed [26:0] vy27, vx27, tn27;
  logic signed [26:0] wh_q [0:3];

  assign vy27 = 27'(rvy_q);
  assign vx27 = 27'(rvx_q);
  assign tn27 = 27'(turn_t_q);

  always_ff @(posedge clk_i) begin
    if (rdy[SS] && v_q[TS]) begin
      wh_q[0] <=  vy27 + vx27 - tn27;
      wh_q[1] <= -vy27 + vx27 - tn27;
      wh_q[2] <= -vy27 - vx27 - tn27;
      wh_q[3] <=  vy27 - vx27 - tn27;
    end
  end

  // --------------------------------------------------------------------------
  // Limiter stage: dead band first, then saturation; this is the output
  // register and holds while the output is stalled
  // --------------------------------------------------------------------------
  function automatic logic signed [22:0] limit(logic signed [26:0] v,
                                               logic [15:0] db,
                                               logic [21:0] mx);
    logic [26:0] mag;
    mag = v[26] ? 27'(-v) : 27'(v);
    if ((v != 27'sd0) && (mag <= 27'(db))) return '0;
    else if (mag > 27'(mx)) return v[26] ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
    else return v[22:0];
  endfunction

  logic signed [22:0] out_q [0:3];

  always_ff @(posedge clk_i) begin
    if (rdy[LAST] && v_q[SS]) begin
      for (int j = 0; j < 4; j++) begin
        out_q[j] <= limit(wh_q[j], dead_band_q, max_speed_q);
      end
    end
  end

  assign wheel_one_o   = out_q[0];
  assign wheel_two_o   = out_q[1];
  assign wheel_three_o = out_q[2];
  assign wheel_four_o  = out_q[3];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // the input may only stall when the whole pipe is full and the output blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&v_q) && out_stall_i))
    else $error("input stalled with a bubble in the pipe");

  // a beat taken at the output with the pipe full must let a new beat in
  a_drain_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while the output drains");

  // a blocked output must keep its result
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(wheel_one_o)))
    else $error("stalled result lost");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mecanum world-to-wheel speed block. A short
// directed table is walked first, then randomised velocity commands are sent
// under a series of register settings. Every wheel beat is checked against its
// table row or the in-bench kinematics predictor, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb;

  localparam int N_STAGES  = 16;
  // stages beyond the cap are not run
  localparam int RUN_STAGES = (N_STAGES > mw2w_pkg::STAGE_CAP) ?
                              mw2w_pkg::STAGE_CAP : N_STAGES;
  localparam int LATENCY    = RUN_STAGES + 6;
  localparam int LIMIT      = 400000;
  localparam int N_PHASES   = 10;
  localparam int MAX_REPORTS = 10;

  // index past the three registers: the block must drop such writes
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] turn;
    logic signed [15:0] heading;
  } command_t;

  // entry 0 is wheel one
  typedef logic [3:0][22:0] wheel_set_t;

  typedef struct packed {
    command_t           cmd;
    logic               known;
    logic signed [22:0] wheel;
  } plan_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [21:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] world_vx_i;
  logic signed [15:0] world_vy_i;
  logic signed [15:0] turn_rate_i;
  logic signed [15:0] heading_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [22:0] wheel_one_o;
  logic signed [22:0] wheel_two_o;
  logic signed [22:0] wheel_three_o;
  logic signed [22:0] wheel_four_o;

  // bench copy of the register file
  logic [7:0]  lever_q;
  logic [15:0] dead_q;
  logic [21:0] max_q;

  wheel_set_t expected_wheels [$];
  int         mismatches;
  int         beats_checked;
  int         commands_sent;
  int         cycle_count;
  bit         calm;

  mecanum_world_to_wheel_speeds #(
    .CORDIC_STAGES(N_STAGES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .world_vx_i   (world_vx_i),
    .world_vy_i   (world_vy_i),
    .turn_rate_i  (turn_rate_i),
    .heading_i    (heading_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .wheel_one_o  (wheel_one_o),
    .wheel_two_o  (wheel_two_o),
    .wheel_three_o(wheel_three_o),
    .wheel_four_o (wheel_four_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Kinematics predictor
  // --------------------------------------------------------------------------

  // atan(2^-i) in Q29 for the first ten steps; later steps use 2^(29-i)
  localparam longint ATAN_STEP [10] = '{
    421657428, 248918915, 131521918, 66762579, 33510843,
    16771758, 8387925, 4194219, 2097141, 1048575
  };

  function automatic longint clip_q15(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // drop the Q15 fraction, rounding toward zero
  function automatic longint drop_q15(longint p);
    if (p >= 0) return p >>> 15;
    return -((-p) >>> 15);
  endfunction

  function automatic void heading_sin_cos(input logic signed [15:0] hd,
                                          output longint sin_q15,
                                          output longint cos_q15);
    longint z, x, y, dx, dy, step;
    bit     flip;
    z    = longint'(hd) * 65536;
    x    = longint'(mw2w_pkg::GAIN_Q30);
    y    = 0;
    flip = 1'b0;
    // fold by pi into the convergence range, negating the vector afterwards
    if (z > longint'(mw2w_pkg::HALF_PI_Q29)) begin
      z    = z - longint'(mw2w_pkg::PI_Q29);
      flip = 1'b1;
    end else if (z < -longint'(mw2w_pkg::HALF_PI_Q29)) begin
      z    = z + longint'(mw2w_pkg::PI_Q29);
      flip = 1'b1;
    end
    for (int i = 0; i < RUN_STAGES; i++) begin
      dx   = y >>> i;
      dy   = x >>> i;
      step = (i < 10) ? ATAN_STEP[i] : (longint'(1) <<< (29 - i));
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - step;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + step;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q15 = clip_q15(x >>> 15);
    sin_q15 = clip_q15(y >>> 15);
  endfunction

  // dead band wins over the limiter
  function automatic longint limit_wheel(longint v);
    longint db, mx;
    db = longint'(dead_q);
    mx = longint'(max_q);
    if (v != 0 && v <= db && v >= -db) return 0;
    if (v > mx) return mx;
    if (v < -mx) return -mx;
    return v;
  endfunction

  function automatic wheel_set_t predict_wheels(command_t c);
    longint     s, co, rvy, rvx, turn, wv;
    wheel_set_t r;
    heading_sin_cos(c.heading, s, co);
    rvy  = drop_q15(longint'(c.vx) * co) + drop_q15(longint'(c.vy) * s);
    rvx  = drop_q15(longint'(c.vx) * s) - drop_q15(longint'(c.vy) * co);
    turn = longint'(c.turn) * longint'(lever_q);
    for (int k = 0; k < 4; k++) begin
      case (k)
        0:       wv =  rvy + rvx - turn;
        1:       wv = -rvy + rvx - turn;
        2:       wv = -rvy - rvx - turn;
        default: wv =  rvy - rvx - turn;
      endcase
      wv   = limit_wheel(wv);
      r[k] = wv[22:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic plan_row_t plan_row(int vx, int vy, int turn, int hd,
                                         bit known, int wheel);
    plan_row_t r;
    r.cmd.vx      = vx[15:0];
    r.cmd.vy      = vy[15:0];
    r.cmd.turn    = turn[15:0];
    r.cmd.heading = hd[15:0];
    r.known       = known;
    r.wheel       = wheel[22:0];
    return r;
  endfunction

  // idle cycles before the next beat on either side
  function automatic int draw_wait();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 0;
    if (pick < 8) return $urandom_range(1, 3);
    return $urandom_range(0, 15);
  endfunction

  // velocity-like field: extremes, small values near zero, or anything
  function automatic logic signed [15:0] draw_speed();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return 16'sh0000;
          3:       return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
      1, 2:    return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] draw_heading();
    case ($urandom_range(0, 7))
      // anywhere in the 16-bit range, beyond +/-pi too
      0: return 16'($urandom);
      // either side of the fold point at +/-pi/2
      1: return 16'($signed($urandom_range(0, 8)) - 4 + 12868) *
                (($urandom_range(0, 1) == 0) ? 16'sd1 : -16'sd1);
      2: return 16'($signed($urandom_range(0, 8)) - 4 + 25736) *
                (($urandom_range(0, 1) == 0) ? 16'sd1 : -16'sd1);
      default: return 16'($signed($urandom_range(0, 51472)) - 25736);
    endcase
  endfunction

  function automatic command_t draw_command();
    command_t c;
    c.vx      = draw_speed();
    c.vy      = draw_speed();
    c.turn    = draw_speed();
    c.heading = draw_heading();
    return c;
  endfunction

  // present one beat, after a random gap, and hold it until it is taken
  task automatic send_command(command_t c);
    int gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    world_vx_i  <= c.vx;
    world_vy_i  <= c.vy;
    turn_rate_i <= c.turn;
    heading_i   <= c.heading;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    commands_sent++;
  endtask

  // drop valid and let every outstanding wheel beat drain
  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_wheels.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [21:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      mw2w_pkg::CFG_LEVER_SUM: lever_q = data[7:0];
      mw2w_pkg::CFG_DEAD_BAND: dead_q  = data[15:0];
      mw2w_pkg::CFG_MAX_SPEED: max_q   = data;
      default: ;
    endcase
  endtask

  // write noise to the spare index, then all three registers, padding the unused upper data bits with noise
  task automatic apply_setting(logic [7:0] lever, logic [15:0] db, logic [21:0] mx);
    logic [21:0] noise;
    noise = 22'($urandom);
    write_register(CFG_SPARE, noise);
    write_register(mw2w_pkg::CFG_LEVER_SUM, {noise[21:8], lever});
    write_register(mw2w_pkg::CFG_DEAD_BAND, {noise[21:16], db});
    write_register(mw2w_pkg::CFG_MAX_SPEED, mx);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Wheel beat checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : wheel_check
    wheel_set_t got, want;
    bit         bad;
    got = {wheel_four_o, wheel_three_o, wheel_two_o, wheel_one_o};
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_wheels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected wheel beat %0d %0d %0d %0d", $realtime,
                   wheel_one_o, wheel_two_o, wheel_three_o, wheel_four_o);
      end else begin
        want = expected_wheels.pop_front();
        bad  = 1'b0;
        for (int k = 0; k < 4; k++) begin
          if (got[k] !== want[k]) begin
            bad = 1'b1;
            if (mismatches < MAX_REPORTS)
              $display("[%0t] wheel %0d: expected %0d, got %0d", $realtime, k + 1,
                       $signed(want[k]), $signed(got[k]));
          end
        end
        if (bad) mismatches++;
        beats_checked++;
      end
    end
  end

  // hold the output stall for a random count, then release it for one beat
  initial begin : wheel_sink
    int hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      hold = draw_wait();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("timed out with %0d wheel beats outstanding", expected_wheels.size());
      $display("mecanum_world_to_wheel_speeds verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    plan_row_t  plan [$];
    wheel_set_t typed;
    command_t   c;
    int         n_items;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = mw2w_pkg::CFG_LEVER_SUM;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    world_vx_i    = '0;
    world_vy_i    = '0;
    turn_rate_i   = '0;
    heading_i     = '0;
    lever_q       = mw2w_pkg::LEVER_SUM_RST;
    dead_q        = mw2w_pkg::DEAD_BAND_RST;
    max_q         = mw2w_pkg::MAX_SPEED_RST;
    mismatches    = 0;
    beats_checked = 0;
    commands_sent = 0;
    cycle_count   = 0;
    calm          = 1'b0;

    // Directed table, run with the reset register values. Rows with no
    // velocity leave only the turn term, so their wheels are known outright.
    //             vx      vy      turn    heading  known  wheel
    plan = '{
      plan_row(     0,      0,      0,       0,     1,          0),
      plan_row(     0,      0,  32767,       0,     1,    -655340),
      plan_row(     0,      0, -32768,       0,     1,     655360),
      plan_row(     0,      0,     -1,   25736,     1,         20),
      plan_row(     0,      0,      1,  -25736,     1,        -20),
      plan_row( 32767,      0,      0,       0,     0,          0),
      plan_row(     0, -32768,      0,       0,     0,          0),
      plan_row(-32768, -32768, -32768,   25736,     0,          0),
      plan_row( 32767,  32767,  32767,  -25736,     0,          0),
      plan_row( 32767, -32768,      0,   32767,     0,          0),
      plan_row(-32768,  32767,      0,  -32768,     0,          0),
      plan_row( 12345,  -6789,    100,   12867,     0,          0),
      plan_row( 12345,  -6789,    100,   12868,     0,          0),
      plan_row( -4321,   9876,   -100,  -12867,     0,          0),
      plan_row( -4321,   9876,   -100,  -12868,     0,          0),
      plan_row(     1,     -1,      1,   21845,     0,          0),
      plan_row(   -1,       1,     -1,  -21846,     0,          0),
      plan_row( 20000,  20000,   5000,    6434,     0,          0)
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      send_command(plan[i].cmd);
      if (plan[i].known) begin
        for (int k = 0; k < 4; k++) typed[k] = plan[i].wheel;
        expected_wheels.push_back(typed);
      end else begin
        expected_wheels.push_back(predict_wheels(plan[i].cmd));
      end
    end
    drain_pipe();

    // Random phases: the first four pin the register extremes, including a
    // dead band at or above the limit; the rest draw settings at random.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: apply_setting(8'd255, 16'd0, mw2w_pkg::MAX_SPEED_RST);
        1: apply_setting(8'd0, 16'd65535, 22'h3FFFFF);
        2: apply_setting(8'd255, 16'd65535, 22'd0);
        3: apply_setting(8'd1, 16'd100, 22'd50);
        default: begin
          apply_setting(8'($urandom),
                        16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 300)
                                                        : $urandom),
                        22'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 70000)
                                                        : $urandom));
        end
      endcase
      // every third phase runs without any idling on either side
      calm    = (p % 3 == 1);
      n_items = $urandom_range(120, 160);
      repeat (n_items) begin
        c = draw_command();
        send_command(c);
        expected_wheels.push_back(predict_wheels(c));
      end
      drain_pipe();
    end

    calm = 1'b0;
    $display("sent %0d commands over %0d register settings plus reset values",
             commands_sent, N_PHASES);
    $display("checked %0d wheel beats, %0d mismatching", beats_checked, mismatches);
    if (mismatches == 0 && expected_wheels.size() == 0) begin
      $display("mecanum_world_to_wheel_speeds verification clean");
    end else begin
      $display("mecanum_world_to_wheel_speeds verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/mw2w_pkg.sv
src/mecanum_world_to_wheel_speeds.sv
tb/tb.sv
